// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

	localparam int unsigned CfgAddrWidth = 3;
	localparam int unsigned CfgDataWidth = 32;

	localparam logic [31:0] MaxPayloadReset  = 32'd1048576;
	localparam logic        RequireMaskReset = 1'b1;

	localparam logic [6:0] Len7ControlMax = 7'd125;
	localparam logic [6:0] Len7Ext16      = 7'd126;
	localparam logic [6:0] Len7Ext64      = 7'd127;
	localparam logic [3:0] Ext16Bytes     = 4'd2;
	localparam logic [3:0] Ext64Bytes     = 4'd8;
	localparam logic [3:0] MaskKeyBytes   = 4'd4;

	typedef enum logic [0:0] {
		REG_MAX_PAYLOAD  = 1'b0,
		REG_REQUIRE_MASK = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_RESERVED = 3'd1,
		ERR_UNMASKED = 3'd2,
		ERR_CONTROL  = 3'd3,
		ERR_TOO_LONG = 3'd4
	} err_t;

endpackage

// ===== hdl/wsd_byte_if.sv =====
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/wsd_result_if.sv =====
interface wsd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic        final_flag;
	logic [3:0]  frame_opcode;
	logic [31:0] frame_length;
	logic        last_of_frame;
	logic [2:0]  error_code;

	modport source (
		output valid, output kind, output payload_byte, output final_flag,
		output frame_opcode, output frame_length, output last_of_frame,
		output error_code, input ready
	);
	modport sink (
		input valid, input kind, input payload_byte, input final_flag,
		input frame_opcode, input frame_length, input last_of_frame,
		input error_code, output ready
	);
endinterface

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket frame deframer.
// The bytes channel takes the raw frame stream, one byte per item. The results
// channel gives one item per payload byte, already unmasked, with the frame's FIN
// bit, opcode and length; last_of_frame marks the final item of each frame. A frame
// with no payload gives one empty-frame item, and a protocol error gives one error
// item, after which every byte is taken and dropped until reset.
// The APB port holds the payload length limit (address 0) and the mask requirement
// (address 4); the user must write it only while the block is idle, which the block does not enforce.
// Each accepted byte lands in an input register and is parsed from there into the
// result register when that register is empty or its item is being taken. One byte
// is taken in every cycle while the receiver does not stall; header bytes give no result.
// The input register lets one byte in while a result waits on a stalled
// receiver; once both registers are full the bytes channel drops ready.
// Reset clears the parser and restores the register defaults (limit of 1048576
// bytes, mask required).
module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CfgAddrWidth-1:0] paddr,
	input  logic [CfgDataWidth-1:0] pwdata,
	output logic [CfgDataWidth-1:0] prdata,
	output logic                    pready,
	wsd_byte_if.sink                bytes,
	wsd_result_if.source            results
);

	logic [31:0] max_q;
	logic        req_q;
	reg_index_t  reg_sel;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	phase_t          phase_q, phase_n;
	logic            fin_q, fin_n;
	logic [3:0]      op_q, op_n;
	logic            mask_q, mask_n;
	logic [63:0]     acc_q, acc_n;
	logic [3:0]      left_q, left_n;
	logic [3:0][7:0] key_q, key_n;
	logic [1:0]      pos_q, pos_n;
	logic [31:0]     pl_q, pl_n;
	logic            err_q, err_n;

	logic        fire;
	kind_t       r_kind;
	logic [7:0]  r_pb;
	logic        r_fin;
	logic [3:0]  r_op;
	logic [31:0] r_len;
	logic        r_last;
	err_t        r_err;

	logic        len_ready;
	logic [63:0] len_val;
	logic [63:0] acc_sh;
	logic [31:0] pl_dec;

	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[2]);

	always_comb begin
		unique case (reg_sel)
			REG_MAX_PAYLOAD:  prdata = max_q;
			REG_REQUIRE_MASK: prdata = {{(CfgDataWidth-1){1'b0}}, req_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MaxPayloadReset;
			req_q <= RequireMaskReset;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_MAX_PAYLOAD:  max_q <= pwdata[31:0];
				REG_REQUIRE_MASK: req_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign advance     = valid_s1 && (!results.valid || results.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		fin_n     = fin_q;
		op_n      = op_q;
		mask_n    = mask_q;
		acc_n     = acc_q;
		left_n    = left_q;
		key_n     = key_q;
		pos_n     = pos_q;
		pl_n      = pl_q;
		err_n     = err_q;
		fire      = 1'b0;
		r_kind    = KIND_PAYLOAD;
		r_pb      = 8'd0;
		r_fin     = fin_q;
		r_op      = op_q;
		r_len     = 32'd0;
		r_last    = 1'b1;
		r_err     = ERR_NONE;
		len_ready = 1'b0;
		len_val   = 64'd0;
		acc_sh    = {acc_q[55:0], byte_s1};
		pl_dec    = pl_q - 32'd1;

		if (!err_q) begin
			unique case (phase_q)
				PH_SECOND: begin
					mask_n = byte_s1[7];
					if (req_q && !byte_s1[7]) begin
						err_n  = 1'b1;
						fire   = 1'b1;
						r_kind = KIND_ERROR;
						r_err  = ERR_UNMASKED;
					end else if (op_q[3] && (!fin_q || byte_s1[6:0] > Len7ControlMax)) begin
						err_n  = 1'b1;
						fire   = 1'b1;
						r_kind = KIND_ERROR;
						r_err  = ERR_CONTROL;
					end else if (byte_s1[6:0] == Len7Ext16) begin
						acc_n   = 64'd0;
						left_n  = Ext16Bytes;
						phase_n = PH_EXTLEN;
					end else if (byte_s1[6:0] == Len7Ext64) begin
						acc_n   = 64'd0;
						left_n  = Ext64Bytes;
						phase_n = PH_EXTLEN;
					end else begin
						len_ready = 1'b1;
						len_val   = {57'd0, byte_s1[6:0]};
					end
				end
				PH_EXTLEN: begin
					acc_n  = acc_sh;
					left_n = left_q - 4'd1;
					if (left_n == 4'd0) begin
						len_ready = 1'b1;
						len_val   = acc_sh;
					end
				end
				PH_MASK: begin
					key_n[2'(~left_q[1:0] + 2'd1)] = byte_s1;
					left_n = left_q - 4'd1;
					if (left_n == 4'd0) begin
						pos_n = 2'd0;
						if (pl_q == 32'd0) begin
							phase_n = PH_FIRST;
							fire    = 1'b1;
							r_kind  = KIND_EMPTY;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					r_pb   = mask_q ? (byte_s1 ^ key_q[pos_q]) : byte_s1;
					pos_n  = pos_q + 2'd1;
					pl_n   = pl_dec;
					r_last = (pl_dec == 32'd0);
					if (pl_dec == 32'd0) begin
						phase_n = PH_FIRST;
					end
					fire   = 1'b1;
					r_kind = KIND_PAYLOAD;
					r_len  = acc_q[31:0];
				end
				default: begin
					fin_n = byte_s1[7];
					op_n  = byte_s1[3:0];
					r_fin = byte_s1[7];
					r_op  = byte_s1[3:0];
					if (byte_s1[6:4] != 3'd0) begin
						err_n  = 1'b1;
						fire   = 1'b1;
						r_kind = KIND_ERROR;
						r_err  = ERR_RESERVED;
					end else begin
						phase_n = PH_SECOND;
					end
				end
			endcase

			if (len_ready) begin
				acc_n = len_val;
				if (len_val[63:32] != 32'd0 || len_val[31:0] > max_q) begin
					err_n  = 1'b1;
					fire   = 1'b1;
					r_kind = KIND_ERROR;
					r_err  = ERR_TOO_LONG;
				end else begin
					pl_n  = len_val[31:0];
					pos_n = 2'd0;
					if (mask_n) begin
						phase_n = PH_MASK;
						left_n  = MaskKeyBytes;
					end else if (len_val[31:0] == 32'd0) begin
						phase_n = PH_FIRST;
						fire    = 1'b1;
						r_kind  = KIND_EMPTY;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			fin_q   <= 1'b0;
			op_q    <= 4'd0;
			mask_q  <= 1'b0;
			acc_q   <= 64'd0;
			left_q  <= 4'd0;
			key_q   <= '0;
			pos_q   <= 2'd0;
			pl_q    <= 32'd0;
			err_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			fin_q   <= fin_n;
			op_q    <= op_n;
			mask_q  <= mask_n;
			acc_q   <= acc_n;
			left_q  <= left_n;
			key_q   <= key_n;
			pos_q   <= pos_n;
			pl_q    <= pl_n;
			err_q   <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (advance) begin
			results.valid <= fire;
		end else if (results.ready) begin
			results.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			results.kind          <= r_kind;
			results.payload_byte  <= r_pb;
			results.final_flag    <= r_fin;
			results.frame_opcode  <= r_op;
			results.frame_length  <= r_len;
			results.last_of_frame <= r_last;
			results.error_code    <= r_err;
		end
	end

endmodule

// ===== hdl/wsd_checker.sv =====
module wsd_checker
	import wsd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_kind,
	input logic [7:0]  res_payload_byte,
	input logic [31:0] res_frame_length,
	input logic        res_last_of_frame,
	input logic [2:0]  res_error_code
);

	// A stalled result item must hold until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
			&& $stable(res_payload_byte) && $stable(res_error_code))
		else $error("result item changed while stalled");

	// Empty-frame and error items always close their frame.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_PAYLOAD |-> res_last_of_frame)
		else $error("non-payload item without last_of_frame");

	// An error item carries a code and no length or data.
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_ERROR |->
			res_error_code != ERR_NONE && res_frame_length == 32'd0
			&& res_payload_byte == 8'd0)
		else $error("malformed error item");

	// Only error items carry an error code.
	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_ERROR |-> res_error_code == ERR_NONE)
		else $error("error code on a non-error item");

	// A payload item of a frame has a nonzero length.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_PAYLOAD |-> res_frame_length != 32'd0)
		else $error("payload item in a zero-length frame");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (results.valid),
	.res_ready         (results.ready),
	.res_kind          (results.kind),
	.res_payload_byte  (results.payload_byte),
	.res_frame_length  (results.frame_length),
	.res_last_of_frame (results.last_of_frame),
	.res_error_code    (results.error_code)
);
